// ===== design/lrukv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the incoming request
        logic lookup;   // match keys, start the value read
        logic update;   // commit ranks, entries and result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_get;  // request held is a get
        logic out_busy; // result register full and not taken this cycle
    } dp_status_t;

endpackage

// ===== design/lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps
// A get passes the lookup state (key match) and the update state (rank update),
// then its result is registered. A new request is taken when idle or in update,
// so it waits for both; a get stalls in update while the last result is unread.
// Reset: entries invalid, ranks and occupancy zero, capacity 16; keys and
// values are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core
#(
    parameter int MAX_ENTRIES = lrukv_pkg::DEFAULT_MAX_ENTRIES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lrukv_pkg::CAP_W-1:0]         cfg_wr_data,   // capacity
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lrukv_pkg::KEY_W+lrukv_pkg::VAL_W-1:0] s_tdata, // key, value
    input  logic [0:0]                          s_tuser,       // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrukv_pkg::VAL_W-1:0]         m_tdata,       // read_value
    output logic [0:0]                          m_tuser        // hit
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    lrukv_pkg::ctrl_cmd_t  cmd;
    lrukv_pkg::dp_status_t sts;
    logic [CNT_W-1:0]      occupancy;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic                  res_hit;

    lrukv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrukv_dp
    #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_cmd_in  (s_tuser[0]),
        .req_key_in  (s_tdata[lrukv_pkg::KEY_W-1:0]),
        .req_val_in  (s_tdata[lrukv_pkg::KEY_W+lrukv_pkg::VAL_W-1:lrukv_pkg::KEY_W]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .res_hit     (res_hit),
        .res_value   (m_tdata),
        .occupancy   (occupancy),
        .match_vec   (match_vec)
    );

    assign m_tuser = res_hit;

    // keys stay unique among valid entries
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one entry matches the key");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CNT_W'(MAX_ENTRIES))
        else $error("occupancy above table size");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occupancy == $past(occupancy)) || (occupancy == $past(occupancy) + CNT_W'(1)))
        else $error("occupancy moved by more than one");

    // a request always passes its lookup state without taking another
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken during lookup");

endmodule

// ===== design/lrukv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_ctrl
// Sequencer for accept, lookup and update of one request at a time.
// ----------------------------------------------------------------------------
module lrukv_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lrukv_pkg::dp_status_t  sts,
    output lrukv_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       stall;
    logic       accept;

    // a get cannot finish while the previous result still sits unread
    assign stall    = sts.req_get && sts.out_busy;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_UPDATE) && !stall);
    assign accept   = s_tvalid && s_tready;

    assign cmd.load   = accept;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.update = (state_reg == ST_UPDATE) && !stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!stall)
                begin
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/lrukv_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_dp
// Entry table: per-entry key match, recency ranks, value memory, result reg.
// ----------------------------------------------------------------------------
module lrukv_dp
#(
    parameter int MAX_ENTRIES = lrukv_pkg::DEFAULT_MAX_ENTRIES,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrukv_pkg::ctrl_cmd_t          cmd,
    output lrukv_pkg::dp_status_t         sts,
    input  logic                          cfg_wr_en,
    input  logic [lrukv_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic                          req_cmd_in,
    input  logic [lrukv_pkg::KEY_W-1:0]   req_key_in,
    input  logic [lrukv_pkg::VAL_W-1:0]   req_val_in,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic                          res_hit,
    output logic [lrukv_pkg::VAL_W-1:0]   res_value,
    output logic [CNT_W-1:0]              occupancy,
    output logic [MAX_ENTRIES-1:0]        match_vec
);

    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;

    // request
    logic                        req_cmd_reg;
    logic [lrukv_pkg::KEY_W-1:0] req_key_reg;
    logic [lrukv_pkg::VAL_W-1:0] req_val_reg;

    // entry table
    logic [lrukv_pkg::KEY_W-1:0] key_reg   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]      valid_reg;
    logic [MAX_ENTRIES-1:0]      valid_next;
    logic [RANK_W-1:0]           rank_reg  [MAX_ENTRIES];
    logic [RANK_W-1:0]           rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]            occ_reg;
    logic [CNT_W-1:0]            occ_next;
    logic [lrukv_pkg::CAP_W-1:0] cap_reg;

    logic [lrukv_pkg::VAL_W-1:0] val_mem [MAX_ENTRIES];
    logic [lrukv_pkg::VAL_W-1:0] rd_data_reg;

    // lookup results
    logic                        hit_c;
    logic [IDX_W-1:0]            hit_idx_c;
    logic                        free_c;
    logic [IDX_W-1:0]            free_idx_c;
    logic [IDX_W-1:0]            victim_idx_c;
    logic [CMP_W-1:0]            cap_eff_c;
    logic                        full_c;
    logic [IDX_W-1:0]            ins_idx_c;

    logic                        lk_hit_reg;
    logic [IDX_W-1:0]            lk_hit_idx_reg;
    logic [RANK_W-1:0]           lk_hit_rank_reg;
    logic                        lk_full_reg;
    logic [IDX_W-1:0]            lk_victim_reg;
    logic [IDX_W-1:0]            lk_ins_reg;

    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [lrukv_pkg::VAL_W-1:0] out_value_reg;

    logic                        req_get;
    logic                        ins_en;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;

    assign req_get      = (req_cmd_reg == lrukv_pkg::CMD_GET);
    assign sts.req_get  = req_get;
    assign sts.out_busy = out_valid_reg && !m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_cmd_reg <= req_cmd_in;
            req_key_reg <= req_key_in;
            req_val_reg <= req_val_in;
        end
    end

    // ---- lookup: per-entry compare and encoders ----
    always_comb
    begin
        hit_c        = 1'b0;
        hit_idx_c    = '0;
        free_c       = 1'b0;
        free_idx_c   = '0;
        victim_idx_c = '0;
        // walk downward so the lowest index wins
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req_key_reg);
            if (match_vec[i])
            begin
                hit_c     = 1'b1;
                hit_idx_c = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_c     = 1'b1;
                free_idx_c = IDX_W'(i);
            end
            // ranks are dense, so the oldest entry holds occupancy - 1
            if (valid_reg[i] && (CNT_W'(rank_reg[i]) == occ_reg - CNT_W'(1)))
            begin
                victim_idx_c = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff_c = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES))
        begin
            cap_eff_c = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff_c = CMP_W'(cap_reg);
        end
        full_c = (CMP_W'(occ_reg) >= cap_eff_c);
        // after eviction the lowest free slot is the lower of the two
        if (full_c && !(free_c && (free_idx_c < victim_idx_c)))
        begin
            ins_idx_c = victim_idx_c;
        end
        else
        begin
            ins_idx_c = free_idx_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            lk_hit_reg      <= hit_c;
            lk_hit_idx_reg  <= hit_idx_c;
            lk_hit_rank_reg <= rank_reg[hit_idx_c];
            lk_full_reg     <= full_c;
            lk_victim_reg   <= victim_idx_c;
            lk_ins_reg      <= ins_idx_c;
            rd_data_reg     <= val_mem[hit_idx_c];
        end
    end

    // ---- update: ranks, valid bits, keys, values ----
    assign ins_en    = cmd.update && !req_get && !lk_hit_reg;
    assign mem_we    = cmd.update && !req_get;
    assign mem_waddr = lk_hit_reg ? lk_hit_idx_reg : lk_ins_reg;

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.update && lk_hit_reg)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < lk_hit_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
                if (IDX_W'(i) == lk_hit_idx_reg)
                begin
                    rank_next[i] = '0;
                end
            end
        end
        else if (ins_en)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (lk_full_reg && (IDX_W'(i) == lk_victim_reg))
                begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
                if (IDX_W'(i) == lk_ins_reg)
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
            end
            if (!lk_full_reg)
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= lrukv_pkg::CAP_RESET;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            // capacity only changes while the table is empty
            if (cfg_wr_en && (occ_reg == '0))
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (ins_en && (IDX_W'(i) == lk_ins_reg))
            begin
                key_reg[i] <= req_key_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            val_mem[mem_waddr] <= req_val_reg;
        end
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update && req_get)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && req_get)
        begin
            out_hit_reg   <= lk_hit_reg;
            out_value_reg <= lk_hit_reg ? rd_data_reg : lrukv_pkg::MISS_VALUE;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign res_hit   = out_hit_reg;
    assign res_value = out_value_reg;
    assign occupancy = occ_reg;

endmodule

// ===== tb/sv/lru_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_checker
// Watches the request, result and capacity ports of the LRU key/value cache.
// It keeps its own copy of the entry table and predicts each get's result.
// Each result is compared, field by field, with the oldest predicted read.
// ----------------------------------------------------------------------------
module lru_cache_checker
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [KEY_W+VAL_W-1:0] s_tdata,
    input  logic [0:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [VAL_W-1:0]       m_tdata,
    input  logic [0:0]             m_tuser,
    output int                     failures,
    output int                     pending
);

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } lookup_result_t;

    bit [KEY_W-1:0] line_key   [MAX_ENTRIES];
    bit [VAL_W-1:0] line_value [MAX_ENTRIES];
    bit             line_valid [MAX_ENTRIES];
    int             line_rank  [MAX_ENTRIES];
    int             occupancy;
    bit [CAP_W-1:0] capacity;

    lookup_result_t pending_reads[$];
    int             mismatch_count = 0;
    int             reads_waiting  = 0;

    assign failures = mismatch_count;
    assign pending  = reads_waiting;

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int usable_entries();
        if (capacity == 0)
            return 1;
        if (capacity > MAX_ENTRIES)
            return MAX_ENTRIES;
        return int'(capacity);
    endfunction

    // Age every entry that was more recent, then make this one the newest.
    task automatic make_newest(input int idx);
        int old_rank;
        old_rank = line_rank[idx];
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (line_valid[i] && line_rank[i] < old_rank)
                line_rank[i]++;
        line_rank[idx] = 0;
    endtask

    task automatic apply_cache_request(input logic cmd, input logic [KEY_W-1:0] key,
                                       input logic [VAL_W-1:0] value);
        int             idx;
        int             victim;
        int             slot;
        lookup_result_t res;
        idx = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (idx < 0 && line_valid[i] && line_key[i] == key)
                idx = i;

        if (cmd == CMD_GET)
        begin
            if (idx >= 0)
            begin
                make_newest(idx);
                res.hit        = 1'b1;
                res.read_value = line_value[idx];
            end
            else
            begin
                res.hit        = 1'b0;
                res.read_value = MISS_VALUE;
            end
            pending_reads.push_back(res);
        end
        else if (idx >= 0)
        begin
            line_value[idx] = value;
            make_newest(idx);
        end
        else
        begin
            // Full: drop the entry with the highest rank.
            if (occupancy >= usable_entries())
            begin
                victim = -1;
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (line_valid[i] && (victim < 0 || line_rank[i] >= line_rank[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    line_valid[victim] = 1'b0;
                    line_rank[victim]  = 0;
                    occupancy--;
                end
            end
            slot = -1;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot < 0 && !line_valid[i])
                    slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (line_valid[i])
                        line_rank[i]++;
                line_key[slot]   = key;
                line_value[slot] = value;
                line_valid[slot] = 1'b1;
                line_rank[slot]  = 0;
                occupancy++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                line_valid[i] = 1'b0;
                line_rank[i]  = 0;
            end
            occupancy = 0;
            capacity  = CAP_RESET;
            pending_reads.delete();
            reads_waiting = 0;
        end
        else
        begin
            // Capacity only takes effect while the table is empty.
            if (cfg_wr_en && occupancy == 0)
                capacity = cfg_wr_data;

            if (s_tvalid && s_tready)
                apply_cache_request(s_tuser[0], s_tdata[KEY_W-1:0],
                                    s_tdata[KEY_W+VAL_W-1:KEY_W]);

            if (m_tvalid && m_tready)
            begin
                if (pending_reads.size() == 0)
                    report_mismatch("unexpected result", m_tdata, '0);
                else
                begin
                    if (m_tuser[0] !== pending_reads[0].hit)
                        report_mismatch("hit", {{(VAL_W-1){1'b0}}, m_tuser[0]},
                                        {{(VAL_W-1){1'b0}}, pending_reads[0].hit});
                    if (m_tdata !== pending_reads[0].read_value)
                        report_mismatch("read_value", m_tdata, pending_reads[0].read_value);
                    void'(pending_reads.pop_front());
                end
            end
            reads_waiting = pending_reads.size();
        end
    end

endmodule

// ===== tb/sv/tb_lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// Stimulus and verdict for the LRU key/value cache core.
// Drives directed and random get/put requests over a small key pool, with
// random gaps and back-pressure, and sets capacity while the cache is idle.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;
    import lrukv_pkg::*;

    localparam int MAX_ENTRIES   = DEFAULT_MAX_ENTRIES;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int SETTLE_CYCLES = 4;
    localparam int POOL_DEPTH    = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CAP_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [KEY_W+VAL_W-1:0] s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [VAL_W-1:0]       m_tdata;
    logic [0:0]             m_tuser;
    int                     failures;
    int                     pending;
    bit                     calm = 1'b0;

    lru_key_value_cache_core #(.MAX_ENTRIES(MAX_ENTRIES)) uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    lru_cache_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .failures    (failures),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int idle_cycles();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, key};
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold off new requests until every read has returned and the block settles.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : request_source
        bit [KEY_W-1:0]   key_pool [POOL_DEPTH];
        int               chosen_cap;
        int               live_entries;
        int               pool_size;
        logic             cmd;
        logic [KEY_W-1:0] key;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_GET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookup on an empty cache.
        send_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);

        // Oversized capacity saturates, zero acts as one; the last write sticks.
        chosen_cap   = $urandom_range(0, 31);
        live_entries = (chosen_cap == 0) ? 1 :
                       (chosen_cap > MAX_ENTRIES) ? MAX_ENTRIES : chosen_cap;
        write_capacity(5'd31);
        write_capacity(5'd0);
        write_capacity(CAP_W'(chosen_cap));

        send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(CMD_PUT, 32'h8000_0000, 32'h1234_5678);
        send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);

        // Fill one past the limit so the oldest key falls out.
        for (int i = 0; i <= live_entries; i++)
            send_request(CMD_PUT, 32'h0000_0100 + i, $urandom());
        send_request(CMD_GET, 32'h0000_0100, 32'h0000_0000);
        send_request(CMD_GET, 32'h0000_0100 + live_entries, 32'h0000_0000);

        // A pool a bit larger than the cache keeps both hits and evictions common.
        pool_size = live_entries + $urandom_range(1, live_entries + 2);
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = $urandom();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            // Cache is not empty here, so this write must be ignored.
            if (n == RANDOM_ITEMS / 2)
                write_capacity(CAP_W'($urandom_range(0, 31)));
            if (n % 400 == 399)
                drain_results();
            cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
            if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, pool_size - 1)];
            else
                key = $urandom();
            send_request(cmd, key, $urandom());
        end

        drain_results();
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
